// ----- rtl/ebu_pkg.sv -----
// shared types and constants of the escape byte unstuffer
`default_nettype none

package ebu_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h54;
  localparam logic [7:0] ESC_CODE_55 = 8'h01;
  localparam logic [7:0] ESC_CODE_54 = 8'h02;
  localparam logic [7:0] DEC_55      = 8'h55;

  localparam logic [1:0] POS_MAX     = 2'd3;

  // one decoded step: a single byte, or a held escape byte followed by data
  typedef struct packed {
    logic       pair;
    logic [7:0] data;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/ebu_front.sv -----
// front end: escape tracking, position count and step classification
`default_nettype none

module ebu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output logic               stall,
  output logic               push,
  output ebu_pkg::op_t       op,
  output logic               esc_pending
);

  logic       pending;
  logic       pending_next;
  logic [1:0] position;
  logic [1:0] position_next;
  logic [1:0] pos_plus1;
  logic [1:0] pos_plus2;
  logic       has_result;
  logic       accept;

  function automatic logic is_len(input logic [1:0] p);
    return (p == 2'd1) || (p == 2'd2);
  endfunction

  assign stall       = q_full;
  assign accept      = valid && !q_full;
  assign push        = accept && has_result;
  assign esc_pending = pending;

  assign pos_plus1 = (position == ebu_pkg::POS_MAX) ? ebu_pkg::POS_MAX : position + 2'd1;
  assign pos_plus2 = (pos_plus1 == ebu_pkg::POS_MAX) ? ebu_pkg::POS_MAX : pos_plus1 + 2'd1;

  always_comb begin
    has_result   = 1'b1;
    pending_next = 1'b0;
    op.pair      = 1'b0;
    op.data      = in_byte;
    op.last      = in_last;
    position_next = pos_plus1;
    if (pending) begin
      if (in_byte == ebu_pkg::ESC_CODE_55) begin
        op.data = ebu_pkg::DEC_55;
      end else if (in_byte == ebu_pkg::ESC_CODE_54) begin
        op.data = ebu_pkg::ESC_BYTE;
      end else if (!is_len(pos_plus1) && in_byte == ebu_pkg::ESC_BYTE && !in_last) begin
        // held escape goes out alone, the new one is held in turn
        op.data      = ebu_pkg::ESC_BYTE;
        op.last      = 1'b0;
        pending_next = 1'b1;
      end else begin
        op.pair       = 1'b1;
        position_next = pos_plus2;
      end
    end else if (!is_len(position) && in_byte == ebu_pkg::ESC_BYTE && !in_last) begin
      has_result    = 1'b0;
      pending_next  = 1'b1;
      position_next = position;
    end
    if (in_last) begin
      pending_next  = 1'b0;
      position_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      position <= 2'd0;
    end else if (accept) begin
      pending  <= pending_next;
      position <= position_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ebu_queue.sv -----
// small fifo between front and back ends
`default_nettype none

module ebu_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  not_empty,
  output logic                  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ebu_back.sv -----
// back end: expands queued steps into output bytes
`default_nettype none

module ebu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ebu_pkg::op_t  q_op,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               second_pending
);

  logic       take;
  logic       pend;
  logic [7:0] pend_byte;
  logic       pend_last;

  assign take           = !out_valid || !out_stall;
  assign pop            = take && !pend && q_valid;
  assign second_pending = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (take) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend      <= q_op.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (pend) begin
        out_byte <= pend_byte;
        out_last <= pend_last;
      end else if (q_valid) begin
        if (q_op.pair) begin
          out_byte <= ebu_pkg::ESC_BYTE;
          out_last <= 1'b0;
        end else begin
          out_byte <= q_op.data;
          out_last <= q_op.last;
        end
        pend_byte <= q_op.data;
        pend_last <= q_op.last;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/escape_byte_unstuffer_core.sv -----
// top level of the escape byte unstuffer
// a result passes through the queue and then the output register before it shows on
//   out_valid; the second byte of a pair is held and follows once the first is taken
// throughput: one item per cycle while in_stall is low; a step that gives two bytes
//   holds the output register for both bytes, absorbed by the QUEUE_DEPTH entry queue
// reset (rst, synchronous): clears escape state, position count, queue and output
`default_nettype none

module escape_byte_unstuffer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  // front to queue
  logic          f_push;
  ebu_pkg::op_t  f_op;
  logic          f_pending;

  // queue to back
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ebu_pkg::op_t  q_op;
  logic [$bits(ebu_pkg::op_t)-1:0] q_rd;

  // back status
  logic          b_pend;

  // front: holds an escape byte until its partner arrives, tracks the
  // length-byte positions and classifies each step
  ebu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (in_valid),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .q_full      (q_full),
    .stall       (in_stall),
    .push        (f_push),
    .op          (f_op),
    .esc_pending (f_pending)
  );

  // decoupling queue, lets the front keep taking items during a pair
  ebu_queue #(
    .WIDTH ($bits(ebu_pkg::op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .wr_data   (f_op),
    .pop       (q_pop),
    .rd_data   (q_rd),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign q_op = ebu_pkg::op_t'(q_rd);

  // back: output register plus a one-byte hold for the second of a pair
  ebu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .second_pending (b_pend)
  );

  // a held second byte always sits behind a shown result
  assert property (@(posedge clk) disable iff (rst) b_pend |-> out_valid)
    else $error("second byte held with no result shown");

  // the first half of a pair is the escape byte and never the final one
  assert property (@(posedge clk) disable iff (rst)
    b_pend |-> (out_byte == ebu_pkg::ESC_BYTE) && !out_last)
    else $error("pair head is not a plain escape byte");

  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) f_push |-> !q_full)
    else $error("queue overflow");

  // end of packet drops any held escape
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_last |=> !f_pending)
    else $error("escape still held after last item");

endmodule

`default_nettype wire
